// File: hdl/sha256_stream_hasher_defines.svh
// Assertion macros used by the checker file of the hasher.
// No dependencies.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// An implication whose consequence is checked at the next clock edge.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/sha_pkg.sv
// Types, constants and the rotate function of the SHA-256 hasher.
// No dependencies.
package sha_pkg;

	typedef logic [31:0] word_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	typedef enum logic [2:0] {
		ST_IDLE,     // taking bytes
		ST_COMP,     // running 64 rounds
		ST_FOLD,     // adding working vars into chain
		ST_PAD,      // writing padding bytes one per cycle
		ST_EMIT      // sending digest words
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       wr_en;      // write one byte to the block buffer
		logic [5:0] wr_addr;
		logic [1:0] wr_sel;     // 0 message byte, 1 pad byte, 2 zero, 3 length byte
		logic       load_vars;  // working vars take the chain words
		logic       round_en;   // run one round
		logic [5:0] round;
		logic       fold;       // chain words += working vars
		logic       init;       // chain words take the initial values
		logic       cnt_inc;    // byte count up by one
		logic [2:0] out_idx;
	} cmd_t;

	localparam logic [1:0] SEL_MSG  = 2'd0;
	localparam logic [1:0] SEL_PAD  = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	function automatic word_t rotr(word_t x, int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// File: hdl/sha256_stream_hasher.sv
// Top level of the byte-stream SHA-256 hasher.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
//
// Input items arrive on s_axis, one per accepted handshake: tdata holds the
// message byte, tuser says whether the byte is present, tlast ends the message.
// Bytes are taken one per cycle while s_axis_tready is high. When the 64-byte
// block buffer fills, s_axis_tready drops while the 64 rounds run on one
// shared round unit, one round per cycle, and the chaining words are updated.
// An end of message writes the padding one byte per cycle up to the end of the
// block (up to 64 bytes), then compresses; when the length field does not fit,
// a second padded block follows. The digest then leaves on m_axis as eight
// items, word 0 first, with tuser the word index and tlast on word 7.
// Word 0 is valid once the padding, the rounds and the fold of the final block
// are done; a second padded block, and a full block completed by the end item,
// are first compressed and folded in the same way before the final block.
// A stall on m_axis holds the current word; no input is taken until all eight
// words are gone. Reset clears the byte count, the buffer fill and the chaining
// words to their initial values; no clearing pass is needed.
module sha256_stream_hasher
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
	input  logic        s_axis_tuser,   // [0] byte_present
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] digest_word
	output logic [2:0]  m_axis_tuser,   // [2:0] word_index
	output logic        m_axis_tlast
);
	cmd_t       cmd;
	logic [2:0] idx;

	sha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.present   (s_axis_tuser),
		.eom       (s_axis_tlast),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_idx   (idx),
		.cmd       (cmd)
	);

	sha_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.msg_byte (s_axis_tdata),
		.out_word (m_axis_tdata)
	);

	assign m_axis_tuser = idx;
	assign m_axis_tlast = (idx == 3'd7);
endmodule

// File: hdl/sha_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module sha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/sha_datapath.sv
// Datapath of the SHA-256 hasher: block buffer, schedule, round unit, chain.
// Depends on sha_pkg and sha_ram.
module sha_datapath
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic [7:0] msg_byte,
	output word_t      out_word
);
	logic [60:0] total_q;
	word_t       chain_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [7:0]  wbyte;
	logic [7:0]  len_byte;
	logic [63:0] bits;
	logic [3:0]  rd_word;
	logic [31:0] rd_data;
	word_t       w_new, t1, t2, s0, s1, e, a;

	assign bits = {total_q, 3'b000};
	always_comb begin
		len_byte = bits[8*(7-cmd.wr_addr[2:0]) +: 8];
		unique case (cmd.wr_sel)
			SEL_MSG:  wbyte = msg_byte;
			SEL_PAD:  wbyte = PAD_BYTE;
			SEL_ZERO: wbyte = 8'h00;
			default:  wbyte = len_byte;
		endcase
	end

	// Block buffer as four byte lanes so that a whole word is read per cycle.
	assign rd_word = cmd.load_vars ? 4'd0 : cmd.round[3:0] + 4'd1;
	for (genvar i = 0; i < 4; i++) begin : g_lane
		sha_ram #(.WIDTH(8), .DEPTH(16)) u_lane (
			.clk   (clk),
			.we    (cmd.wr_en && cmd.wr_addr[1:0] == 2'(3 - i)),
			.waddr (cmd.wr_addr[5:2]),
			.wdata (wbyte),
			.raddr (rd_word),
			.rdata (rd_data[8*i +: 8])
		);
	end

	always_comb begin
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new = (cmd.round < 6'd16) ? rd_data : s1 + w_q[9] + s0 + w_q[0];
		a = v_q[0];
		e = v_q[4];
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[cmd.round] + w_new;
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			chain_q <= INIT_H;
		end else begin
			if (cmd.init) begin
				chain_q <= INIT_H;
				total_q <= '0;
			end else begin
				if (cmd.cnt_inc) begin
					total_q <= total_q + 61'd1;
				end
				if (cmd.fold) begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + v_q[i];
					end
				end
			end
		end
	end

	// Schedule is a shift line: w_q[15] is the newest word.
	always_ff @(posedge clk) begin
		if (cmd.load_vars) begin
			v_q <= chain_q;
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign out_word = chain_q[cmd.out_idx];
endmodule

// File: hdl/sha_ctrl.sv
// Controller of the SHA-256 hasher: byte intake, padding, rounds, digest output.
// Depends on sha_pkg.
module sha_ctrl
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       present,
	input  logic       eom,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [2:0] out_idx,
	output cmd_t       cmd
);
	state_t     state_q, state_d;
	logic [5:0] fill_q;
	logic [5:0] round_q;
	logic       final_q;    // a pending end of message
	logic       padded_q;   // the pad byte is written
	logic       last_q;     // the block in flight is the final one
	logic [2:0] idx_q;
	logic       take;

	assign take = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_idx = idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (present && fill_q == 6'd63) begin
						state_d = ST_COMP;
					end else if (eom) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				if (round_q == 6'd63) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				if (last_q) begin
					state_d = ST_EMIT;
				end else if (final_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				if (fill_q == 6'd63) begin
					state_d = ST_COMP;
				end
			end
			ST_EMIT: begin
				if (out_ready && idx_q == 3'd7) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_idx = idx_q;
		cmd.wr_addr = fill_q;
		cmd.round = round_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.wr_en = take && present;
				cmd.wr_sel = SEL_MSG;
				cmd.cnt_inc = take && present;
				cmd.load_vars = take && present && fill_q == 6'd63;
			end
			ST_COMP: begin
				cmd.round_en = 1'b1;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
			end
			ST_PAD: begin
				cmd.wr_en = 1'b1;
				if (!padded_q) begin
					cmd.wr_sel = SEL_PAD;
				end else if (last_q && fill_q >= LEN_POS) begin
					cmd.wr_sel = SEL_LEN;
				end else begin
					cmd.wr_sel = SEL_ZERO;
				end
				cmd.load_vars = (fill_q == 6'd63);
			end
			ST_EMIT: begin
				cmd.init = out_ready && idx_q == 3'd7;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			round_q <= '0;
			final_q <= 1'b0;
			padded_q <= 1'b0;
			last_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (present) begin
							fill_q <= fill_q + 6'd1;
						end
						final_q <= eom;
						padded_q <= 1'b0;
						// Pad and length fit in this block unless the pad byte lands past 55.
						last_q <= (present ? fill_q + 6'd1 : fill_q) < LEN_POS
							&& !(present && fill_q == 6'd63);
					end
					round_q <= '0;
				end
				ST_COMP: round_q <= round_q + 6'd1;
				ST_FOLD: begin
					round_q <= '0;
					if (final_q && !last_q) begin
						last_q <= (padded_q || fill_q < LEN_POS);
					end
				end
				ST_PAD: begin
					padded_q <= 1'b1;
					fill_q <= fill_q + 6'd1;
				end
				ST_EMIT: begin
					if (out_ready) begin
						idx_q <= idx_q + 3'd1;
					end
					if (out_ready && idx_q == 3'd7) begin
						final_q <= 1'b0;
						last_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: hdl/sha_checker.sv
// Port-level checker of the SHA-256 hasher, bound to the top level.
// Depends on sha256_stream_hasher_defines.svh.
`include "sha256_stream_hasher_defines.svh"
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser,
	input logic        m_axis_tlast
)
;
	`SHA_ASSERT_IMPL(a_no_overlap, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`SHA_ASSERT_IMPL(a_last_is_seven, clk, arst_n, m_axis_tvalid,
		m_axis_tlast == (m_axis_tuser == 3'd7))
	`SHA_ASSERT_NEXT(a_index_steps, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !m_axis_tlast,
		m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
	`SHA_ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
